/* src/sckb_pkg.sv */
// Package: shared types and constants for the scaled colour-key blit core.
`default_nettype none
package sckb_pkg;

	// Transparent colour key
	localparam logic [31:0] KEY_COLOR = 32'hFF00_0000;

	// Field widths
	localparam int COLOR_W  = 32;
	localparam int TILE_W   = 8;
	localparam int ORIGIN_W = 9;
	localparam int OFFSET_W = 25;
	localparam int LINE_W   = 14;
	localparam int PBITS_W  = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIN_W_TILES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_H_TILES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_BYTES  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BITS  = 2'd3;

	// Configuration registers as seen by the datapath
	typedef struct packed {
		logic [TILE_W-1:0]  win_w_tiles;
		logic [TILE_W-1:0]  win_h_tiles;
		logic [LINE_W-1:0]  line_bytes;
		logic [PBITS_W-1:0] pixel_bits;
	} cfg_t;

	// One kept pixel, in window tile coordinates
	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic [TILE_W-1:0]  tile_x;
		logic [TILE_W-1:0]  tile_y;
	} blit_item_t;

endpackage
`default_nettype wire

/* src/sckb_front.sv */
// Front end: accepts sprite pixels, drops keyed and clipped ones, queues the rest.
`default_nettype none
module sckb_front
	import sckb_pkg::*;
(
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [COLOR_W-1:0]   pixel_color,
	input  wire logic [TILE_W-1:0]    sprite_col,
	input  wire logic [TILE_W-1:0]    sprite_row,
	input  wire logic [ORIGIN_W-1:0]  origin_x,
	input  wire logic [ORIGIN_W-1:0]  origin_y,
	input  wire cfg_t                 cfg,
	input  wire logic                 q_full,
	output logic                      q_push,
	output blit_item_t                q_item
);

	logic signed [ORIGIN_W:0] tile_x;
	logic signed [ORIGIN_W:0] tile_y;
	logic                     in_x;
	logic                     in_y;
	logic                     keyed;

	// Tile position in the window; the block is a whole tile, so it is kept or dropped whole
	assign tile_x = $signed({2'b00, sprite_col}) + $signed({origin_x[ORIGIN_W-1], origin_x});
	assign tile_y = $signed({2'b00, sprite_row}) + $signed({origin_y[ORIGIN_W-1], origin_y});
	assign in_x   = !tile_x[ORIGIN_W] && (tile_x[ORIGIN_W-1:0] < {1'b0, cfg.win_w_tiles});
	assign in_y   = !tile_y[ORIGIN_W] && (tile_y[ORIGIN_W-1:0] < {1'b0, cfg.win_h_tiles});
	assign keyed  = (pixel_color == KEY_COLOR);

	// Accept while the queue has room
	assign busy   = q_full;
	assign q_push = start && !q_full && !keyed && in_x && in_y;

	assign q_item.color  = pixel_color;
	assign q_item.tile_x = tile_x[TILE_W-1:0];
	assign q_item.tile_y = tile_y[TILE_W-1:0];

endmodule
`default_nettype wire

/* src/sckb_queue.sv */
// Two-entry queue between the front end and the write generator.
`default_nettype none
module sckb_queue
	import sckb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire blit_item_t  push_item,
	output logic             full,
	input  wire logic        pop,
	output logic             valid,
	output blit_item_t       head
);

	blit_item_t  mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign head  = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

/* src/sckb_back.sv */
// Back end: walks each queued pixel's block and produces one frame-buffer write per cycle.
`default_nettype none
module sckb_back
	import sckb_pkg::*;
#(
	parameter int SCALE = 4
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cfg_t                 cfg,
	input  wire logic                 q_valid,
	input  wire blit_item_t           q_head,
	output logic                      q_pop,
	output logic                      write_valid,
	output logic [OFFSET_W-1:0]       byte_offset,
	output logic [COLOR_W-1:0]        write_color,
	output logic                      last_write
);

	localparam int CW  = (SCALE > 1) ? $clog2(SCALE) : 1;
	localparam int PW  = TILE_W + CW;
	localparam int RPW = PW + LINE_W;
	localparam int CPW = PW + PBITS_W;
	localparam logic [CW-1:0] LAST_IDX = CW'(SCALE - 1);

	blit_item_t      item_q;
	logic            active_q;
	logic [CW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	logic            at_last;
	logic [PW-1:0]   pos_x;
	logic [PW-1:0]   pos_y;

	logic                valid_s1;
	logic                last_s1;
	logic [COLOR_W-1:0]  color_s1;
	logic [RPW-1:0]      row_prod_s1;
	logic [CPW-1:0]      col_prod_s1;

	assign at_last = (row_q == LAST_IDX) && (col_q == LAST_IDX);
	assign q_pop   = q_valid && (!active_q || at_last);

	// Block walk: rows top to bottom, columns left to right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
		end else if (q_pop) begin
			active_q <= 1'b1;
			row_q    <= '0;
			col_q    <= '0;
		end else if (active_q) begin
			if (at_last) begin
				active_q <= 1'b0;
			end else if (col_q == LAST_IDX) begin
				col_q <= '0;
				row_q <= row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_head;
		end
	end

	// Pixel position of the current write
	assign pos_x = PW'(item_q.tile_x) * PW'(SCALE) + PW'(col_q);
	assign pos_y = PW'(item_q.tile_y) * PW'(SCALE) + PW'(row_q);

	// Stage 1: row and column products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		last_s1     <= at_last;
		color_s1    <= item_q.color;
		row_prod_s1 <= RPW'(pos_y) * RPW'(cfg.line_bytes);
		col_prod_s1 <= CPW'(pos_x) * CPW'(cfg.pixel_bits);
	end

	// Stage 2: offset sum, wraps at the offset width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_valid <= 1'b0;
			last_write  <= 1'b0;
		end else begin
			write_valid <= valid_s1;
			last_write  <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		write_color <= color_s1;
		byte_offset <= OFFSET_W'(row_prod_s1) + OFFSET_W'(col_prod_s1 >> 3);
	end

endmodule
`default_nettype wire

/* src/scaled_color_key_blit_core.sv */
// Top level: scaled sprite blit with colour key.
//
// Usage:
//  - A sprite pixel is transferred at a clock edge with start high and busy low.
//  - A pixel whose colour is the key, or whose tile lies outside the window,
//    is dropped at once and gives no writes; the next pixel may follow next cycle.
//  - A kept pixel gives SCALE*SCALE writes, one per cycle, rows top to bottom;
//    write_valid marks each, last_write marks the final one of the pixel.
//  - The first write follows the transfer through the queue, the walker and
//    the product and offset-sum stages; the walker takes a new kept pixel only
//    as it walks the last write of the one before. A two-entry queue lets the
//    front keep taking pixels while the walker works; busy rises when it is full.
//  - The receiver cannot stall: each write is shown for exactly one cycle.
//  - Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//    and must be made while no pixel is in flight; the core does not enforce this.
//  - Reset empties the queue and pipeline and loads the window 32x32 tiles,
//    512 bytes per line and 32 bits per pixel.
`default_nettype none
module scaled_color_key_blit_core
	import sckb_pkg::*;
#(
	parameter int SCALE = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [COLOR_W-1:0]     pixel_color,
	input  wire logic [TILE_W-1:0]      sprite_col,
	input  wire logic [TILE_W-1:0]      sprite_row,
	input  wire logic [ORIGIN_W-1:0]    origin_x,
	input  wire logic [ORIGIN_W-1:0]    origin_y,
	output logic                        write_valid,
	output logic [OFFSET_W-1:0]         byte_offset,
	output logic [COLOR_W-1:0]          write_color,
	output logic                        last_write
);

	cfg_t        cfg_q;
	logic        q_full;
	logic        q_push;
	logic        q_pop;
	logic        q_valid;
	blit_item_t  q_item;
	blit_item_t  q_head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_w_tiles <= TILE_W'(32);
			cfg_q.win_h_tiles <= TILE_W'(32);
			cfg_q.line_bytes  <= LINE_W'(512);
			cfg_q.pixel_bits  <= PBITS_W'(32);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIN_W_TILES: cfg_q.win_w_tiles <= cfg_data[TILE_W-1:0];
				REG_WIN_H_TILES: cfg_q.win_h_tiles <= cfg_data[TILE_W-1:0];
				REG_LINE_BYTES:  cfg_q.line_bytes  <= cfg_data[LINE_W-1:0];
				REG_PIXEL_BITS:  cfg_q.pixel_bits  <= cfg_data[PBITS_W-1:0];
				default: ;
			endcase
		end
	end

	sckb_front u_front (
		.start       (start),
		.busy        (busy),
		.pixel_color (pixel_color),
		.sprite_col  (sprite_col),
		.sprite_row  (sprite_row),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.cfg         (cfg_q),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_item      (q_item)
	);

	sckb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	sckb_back #(
		.SCALE (SCALE)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.write_valid (write_valid),
		.byte_offset (byte_offset),
		.write_color (write_color),
		.last_write  (last_write)
	);

endmodule
`default_nettype wire

/* src/sckb_checker.sv */
// Port-level checks for the blit core, bound to its top level.
`default_nettype none
module sckb_checker
	import sckb_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 write_valid,
	input wire logic                 last_write,
	input wire logic [COLOR_W-1:0]   write_color
);

	// The last-write mark only comes with a write
	assert property (@(posedge clk) disable iff (!arst_n)
		last_write |-> write_valid)
		else $error("last_write without write_valid");

	// A pixel's writes come in an unbroken run up to its last one
	assert property (@(posedge clk) disable iff (!arst_n)
		write_valid && !last_write |=> write_valid)
		else $error("write run broken before last write");

	// All writes of one pixel carry the same colour
	assert property (@(posedge clk) disable iff (!arst_n)
		write_valid && !last_write |=> write_color == $past(write_color))
		else $error("colour changed within a pixel's block");

endmodule

bind scaled_color_key_blit_core sckb_checker u_sckb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.write_valid (write_valid),
	.last_write  (last_write),
	.write_color (write_color)
);
`default_nettype wire
